### rtl/core/pza_pkg.sv
// Shared types, sizes and codes of the purgeable zone allocator.
package pza_pkg;

  localparam int HEAP_PARAGRAPHS = 32768;
  localparam int HANDLE_COUNT    = 256;
  localparam int AW              = $clog2(HEAP_PARAGRAPHS);
  localparam int IDX_W           = AW + 1;
  localparam int HW              = $clog2(HANDLE_COUNT);
  localparam int OWNER_W         = 8;
  localparam int GUARD_W         = IDX_W + 3;

  localparam logic [IDX_W-1:0]   SENT_IDX    = IDX_W'(HEAP_PARAGRAPHS);
  localparam logic [GUARD_W-1:0] GUARD_ALLOC = GUARD_W'(4 * (HEAP_PARAGRAPHS + 2));
  localparam logic [GUARD_W-1:0] GUARD_WALK  = GUARD_W'(HEAP_PARAGRAPHS + 2);

  localparam logic [15:0] HP_RESET = 16'(HEAP_PARAGRAPHS);
  localparam logic [10:0] MF_RESET = 11'd64;

  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_ALLOC  = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_CHTAG  = 3'd3;
  localparam logic [2:0] OP_FLEVEL = 3'd4;
  localparam logic [2:0] OP_QUERY  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_DEAD  = 2'd2;

  localparam logic [2:0] TAG_STATIC  = 3'd1;
  localparam logic [2:0] TAG_LEVEL   = 3'd2;
  localparam logic [2:0] TAG_LEVSPEC = 3'd3;
  localparam logic [2:0] TAG_PURGE   = 3'd4;

  localparam logic CFG_HEAP = 1'b0;
  localparam logic CFG_MINF = 1'b1;

  typedef struct packed {
    logic               head;
    logic               used;
    logic [2:0]         tag;
    logic [OWNER_W-1:0] owner;
    logic [IDX_W-1:0]   size;
    logic [IDX_W-1:0]   nxt;
    logic [IDX_W-1:0]   prv;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

endpackage

### rtl/core/pza_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pza_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/purgeable_zone_allocator_unit.sv
// Top level of the purgeable zone allocator: header walker and sequencer.
//
//  channel | ports                       | payload
//  --------+-----------------------------+-------------------------------------------
//  input   | in_tvalid/in_tready         | tuser operation, tdata size/tag/addr/owner
//  result  | out_tvalid/out_tready       | tuser status, tdata result_address
//  config  | cfg_wr_en/cfg_addr          | cfg_wdata register value
//
// One word at a time; in_tready only in idle. Each header visit goes through
// the registered read port of the header RAM. After reset a clearing pass
// sweeps the 32768 header slots (and the handle table) and plants the first
// block before the first word is taken; init repeats the header sweep.
// A finished result sits in the output register while the next word is taken.
module purgeable_zone_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // size_bytes[15:0], block_tag[18:16], address[33:19],
                                  // owner[41:34], zero[47:42]
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_address[14:0], zero[15]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int IW = pza_pkg::IDX_W;
  localparam int AW = pza_pkg::AW;
  localparam int HW = pza_pkg::HW;
  localparam int GW = pza_pkg::GUARD_W;

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_CLR   = 6'd1;
  localparam logic [5:0] S_INIT0 = 6'd2;
  localparam logic [5:0] S_DONE  = 6'd3;
  localparam logic [5:0] S_LV_RD = 6'd4;
  localparam logic [5:0] S_LV_CK = 6'd5;
  localparam logic [5:0] S_Q_RD  = 6'd6;
  localparam logic [5:0] S_Q_CK  = 6'd7;
  localparam logic [5:0] S_FB0   = 6'd8;
  localparam logic [5:0] S_FB1   = 6'd9;
  localparam logic [5:0] S_FB2   = 6'd10;
  localparam logic [5:0] S_FB3   = 6'd11;
  localparam logic [5:0] S_FB4   = 6'd12;
  localparam logic [5:0] S_FB5   = 6'd13;
  localparam logic [5:0] S_FB6   = 6'd14;
  localparam logic [5:0] S_FB7   = 6'd15;
  localparam logic [5:0] S_FB8   = 6'd16;
  localparam logic [5:0] S_FB9   = 6'd17;
  localparam logic [5:0] S_AL0   = 6'd18;
  localparam logic [5:0] S_AL1   = 6'd19;
  localparam logic [5:0] S_AL2   = 6'd20;
  localparam logic [5:0] S_LP    = 6'd21;
  localparam logic [5:0] S_LP1   = 6'd22;
  localparam logic [5:0] S_PG0   = 6'd23;
  localparam logic [5:0] S_PG1   = 6'd24;
  localparam logic [5:0] S_PG2   = 6'd25;
  localparam logic [5:0] S_PG3   = 6'd26;
  localparam logic [5:0] S_CD    = 6'd27;
  localparam logic [5:0] S_CD1   = 6'd28;
  localparam logic [5:0] S_SP0   = 6'd29;
  localparam logic [5:0] S_SP1   = 6'd30;
  localparam logic [5:0] S_SP2   = 6'd31;
  localparam logic [5:0] S_SP3   = 6'd32;
  localparam logic [5:0] S_FL0   = 6'd33;
  localparam logic [5:0] S_FL1   = 6'd34;
  localparam logic [5:0] S_FL2   = 6'd35;
  localparam logic [5:0] S_FL3   = 6'd36;

  // input fields
  logic [15:0] f_size;
  logic [2:0]  f_tag;
  logic [14:0] f_addr;
  logic [7:0]  f_owner;
  assign f_size  = in_tdata[15:0];
  assign f_tag   = in_tdata[18:16];
  assign f_addr  = in_tdata[33:19];
  assign f_owner = in_tdata[41:34];

  logic [5:0]  st_r, st_nxt, ret_r, ret_nxt;
  logic [2:0]  op_r, op_nxt, tag_r, tag_nxt;
  logic [7:0]  owner_r, owner_nxt;
  logic [IW-1:0] need_r, need_nxt, b_r, b_nxt, p_r, p_nxt, n_r, n_nxt;
  logic [IW-1:0] base_r, base_nxt, cur_r, cur_nxt, start_r, start_nxt;
  logic [IW-1:0] before_r, before_nxt, rover_r, rover_nxt;
  logic [IW-1:0] sent_next_r, sent_next_nxt, sent_prev_r, sent_prev_nxt;
  logic [GW-1:0] guard_r, guard_nxt;
  pza_pkg::hdr_t hA_r, hA_nxt, hB_r, hB_nxt;
  logic [1:0]  status_r, status_nxt, out_status_r, out_status_nxt;
  logic [AW-1:0] res_r, res_nxt, out_addr_r, out_addr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic        clr_hnd_r, clr_hnd_nxt, clr_op_r, clr_op_nxt;
  logic [15:0] hp_r;
  logic [10:0] mf_r;
  logic [15:0] hp_clamp;

  // memory ports
  logic          hdr_we, hdr_ram_we;
  logic [IW-1:0] hdr_wi, rd_idx;
  pza_pkg::hdr_t wr_hdr, rh, sent_hdr;
  logic [pza_pkg::HDR_W-1:0] hdr_rdata;
  logic          rd_sent_r;
  logic          hnd_we;
  logic [HW-1:0] hnd_wa, hnd_ra;
  logic [AW-1:0] hnd_wd, hnd_rdata;
  logic [IW-1:0] left_w, nb_w;

  pza_ram #(.W(pza_pkg::HDR_W), .D(pza_pkg::HEAP_PARAGRAPHS)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_ram_we),
    .waddr (hdr_wi[AW-1:0]),
    .wdata (wr_hdr),
    .raddr (rd_idx[AW-1:0]),
    .rdata (hdr_rdata)
  );

  pza_ram #(.W(AW), .D(pza_pkg::HANDLE_COUNT)) u_hnd_ram (
    .clk   (clk),
    .we    (hnd_we),
    .waddr (hnd_wa),
    .wdata (hnd_wd),
    .raddr (hnd_ra),
    .rdata (hnd_rdata)
  );

  assign hdr_ram_we = hdr_we && (hdr_wi != pza_pkg::SENT_IDX);

  // sentinel lives in flops: always in use, tag static
  always_comb begin
    sent_hdr       = '0;
    sent_hdr.used  = 1'b1;
    sent_hdr.tag   = pza_pkg::TAG_STATIC;
    sent_hdr.nxt   = sent_next_r;
    sent_hdr.prv   = sent_prev_r;
  end

  assign rh = rd_sent_r ? sent_hdr : pza_pkg::hdr_t'(hdr_rdata);

  assign left_w = hB_r.size - need_r;
  assign nb_w   = base_r + need_r;

  always_comb begin
    if (hp_r < 16'd2) begin
      hp_clamp = 16'd2;
    end else if (hp_r > pza_pkg::HP_RESET) begin
      hp_clamp = pza_pkg::HP_RESET;
    end else begin
      hp_clamp = hp_r;
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_addr_r};

  always_comb begin
    st_nxt        = st_r;
    ret_nxt       = ret_r;
    op_nxt        = op_r;
    tag_nxt       = tag_r;
    owner_nxt     = owner_r;
    need_nxt      = need_r;
    b_nxt         = b_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    base_nxt      = base_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    before_nxt    = before_r;
    rover_nxt     = rover_r;
    sent_next_nxt = sent_next_r;
    sent_prev_nxt = sent_prev_r;
    guard_nxt     = guard_r;
    hA_nxt        = hA_r;
    hB_nxt        = hB_r;
    status_nxt    = status_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt  = out_addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_hnd_nxt   = clr_hnd_r;
    clr_op_nxt    = clr_op_r;
    hdr_we        = 1'b0;
    hdr_wi        = '0;
    wr_hdr        = '0;
    rd_idx        = '0;
    hnd_we        = 1'b0;
    hnd_wa        = '0;
    hnd_wd        = '0;
    hnd_ra        = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tuser;
          tag_nxt    = f_tag;
          owner_nxt  = f_owner;
          status_nxt = pza_pkg::ST_OK;
          res_nxt    = '0;
          need_nxt   = IW'(f_size[15:4]) + IW'(|f_size[3:0]) + IW'(1);
          b_nxt      = IW'(f_addr) - IW'(1);
          case (in_tuser)
            pza_pkg::OP_INIT: begin
              clr_cnt_nxt = '0;
              clr_hnd_nxt = 1'b0;
              clr_op_nxt  = 1'b1;
              st_nxt      = S_CLR;
            end
            pza_pkg::OP_ALLOC: st_nxt = S_AL0;
            pza_pkg::OP_FREE, pza_pkg::OP_CHTAG: begin
              if (f_addr == '0) begin
                status_nxt = pza_pkg::ST_DEAD;
                st_nxt     = S_DONE;
              end else begin
                st_nxt = S_LV_RD;
              end
            end
            pza_pkg::OP_FLEVEL: begin
              b_nxt     = sent_next_r;
              guard_nxt = pza_pkg::GUARD_WALK;
              st_nxt    = S_FL0;
            end
            pza_pkg::OP_QUERY: st_nxt = S_Q_RD;
            default: st_nxt = S_DONE;
          endcase
        end
      end

      // sweep every header slot; the reset pass also zeroes the handle table
      S_CLR: begin
        hdr_we = 1'b1;
        hdr_wi = IW'(clr_cnt_r);
        if (clr_hnd_r && (32'(clr_cnt_r) < pza_pkg::HANDLE_COUNT)) begin
          hnd_we = 1'b1;
          hnd_wa = HW'(clr_cnt_r);
        end
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(pza_pkg::HEAP_PARAGRAPHS - 1)) begin
          st_nxt = S_INIT0;
        end
      end

      S_INIT0: begin
        hdr_we        = 1'b1;
        hdr_wi        = '0;
        wr_hdr.head   = 1'b1;
        wr_hdr.size   = IW'(hp_clamp);
        wr_hdr.nxt    = pza_pkg::SENT_IDX;
        wr_hdr.prv    = pza_pkg::SENT_IDX;
        sent_next_nxt = '0;
        sent_prev_nxt = '0;
        rover_nxt     = '0;
        st_nxt        = clr_op_r ? S_DONE : S_IDLE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_addr_nxt   = res_r;
          st_nxt         = S_IDLE;
        end
      end

      S_LV_RD: begin
        rd_idx = b_r;
        st_nxt = S_LV_CK;
      end

      S_LV_CK: begin
        if (!rh.head || !rh.used) begin
          status_nxt = pza_pkg::ST_DEAD;
          st_nxt     = S_DONE;
        end else if (op_r == pza_pkg::OP_FREE) begin
          hA_nxt  = rh;
          ret_nxt = S_DONE;
          st_nxt  = S_FB0;
        end else begin
          hdr_we     = 1'b1;
          hdr_wi     = b_r;
          wr_hdr     = rh;
          wr_hdr.tag = tag_r;
          st_nxt     = S_DONE;
        end
      end

      S_Q_RD: begin
        hnd_ra = HW'(owner_r);
        st_nxt = S_Q_CK;
      end

      S_Q_CK: begin
        if (32'(owner_r) < pza_pkg::HANDLE_COUNT) begin
          res_nxt = hnd_rdata;
        end
        st_nxt = S_DONE;
      end

      // release block b_r (header in hA_r), merge with prev then next
      S_FB0: begin
        if (hA_r.owner != '0) begin
          hnd_we = 1'b1;
          hnd_wa = HW'(hA_r.owner);
        end
        hA_nxt.used  = 1'b0;
        hA_nxt.tag   = '0;
        hA_nxt.owner = '0;
        p_nxt        = hA_r.prv;
        rd_idx       = hA_r.prv;
        st_nxt       = S_FB1;
      end

      S_FB1: begin
        hdr_we = 1'b1;
        if (!rh.used) begin
          hB_nxt      = rh;
          hB_nxt.size = rh.size + hA_r.size;
          hB_nxt.nxt  = hA_r.nxt;
          hdr_wi      = p_r;
          wr_hdr      = hB_nxt;
          st_nxt      = S_FB2;
        end else begin
          hdr_wi = b_r;
          wr_hdr = hA_r;
          st_nxt = S_FB5;
        end
      end

      S_FB2: begin
        hdr_we      = 1'b1;
        hdr_wi      = b_r;
        wr_hdr      = hA_r;
        wr_hdr.head = 1'b0;
        if (rover_r == b_r) begin
          rover_nxt = p_r;
        end
        st_nxt = S_FB3;
      end

      S_FB3: begin
        rd_idx = hA_r.nxt;
        st_nxt = S_FB4;
      end

      S_FB4: begin
        hdr_we     = 1'b1;
        hdr_wi     = hA_r.nxt;
        wr_hdr     = rh;
        wr_hdr.prv = p_r;
        b_nxt      = p_r;
        hA_nxt     = hB_r;
        st_nxt     = S_FB5;
      end

      S_FB5: begin
        n_nxt  = hA_r.nxt;
        rd_idx = hA_r.nxt;
        st_nxt = S_FB6;
      end

      S_FB6: begin
        if (!rh.used) begin
          hA_nxt.size = hA_r.size + rh.size;
          hA_nxt.nxt  = rh.nxt;
          hB_nxt      = rh;
          hdr_we      = 1'b1;
          hdr_wi      = b_r;
          wr_hdr      = hA_nxt;
          if (rover_r == n_r) begin
            rover_nxt = b_r;
          end
          st_nxt = S_FB7;
        end else begin
          st_nxt = ret_r;
        end
      end

      S_FB7: begin
        rd_idx = hB_r.nxt;
        st_nxt = S_FB8;
      end

      S_FB8: begin
        hdr_we     = 1'b1;
        hdr_wi     = hB_r.nxt;
        wr_hdr     = rh;
        wr_hdr.prv = b_r;
        st_nxt     = S_FB9;
      end

      S_FB9: begin
        hdr_we      = 1'b1;
        hdr_wi      = n_r;
        wr_hdr      = hB_r;
        wr_hdr.head = 1'b0;
        st_nxt      = ret_r;
      end

      // alloc: back up over a free block before the rover, then walk
      S_AL0: begin
        base_nxt = rover_r;
        rd_idx   = rover_r;
        st_nxt   = S_AL1;
      end

      S_AL1: begin
        start_nxt = rh.prv;
        p_nxt     = rh.prv;
        rd_idx    = rh.prv;
        st_nxt    = S_AL2;
      end

      S_AL2: begin
        guard_nxt = pza_pkg::GUARD_ALLOC;
        if (!rh.used) begin
          base_nxt  = p_r;
          start_nxt = rh.prv;
          cur_nxt   = p_r;
        end else begin
          cur_nxt = base_r;
        end
        st_nxt = S_LP;
      end

      S_LP: begin
        if (cur_r == start_r || guard_r == '0) begin
          status_nxt = pza_pkg::ST_NOFIT;
          st_nxt     = S_DONE;
        end else begin
          guard_nxt = guard_r - GW'(1);
          rd_idx    = cur_r;
          st_nxt    = S_LP1;
        end
      end

      S_LP1: begin
        if (rh.used) begin
          if (rh.tag < pza_pkg::TAG_PURGE) begin
            cur_nxt  = rh.nxt;
            base_nxt = rh.nxt;
            st_nxt   = S_CD;
          end else begin
            hA_nxt = rh;
            b_nxt  = cur_r;
            rd_idx = base_r;
            st_nxt = S_PG0;
          end
        end else begin
          cur_nxt = rh.nxt;
          st_nxt  = S_CD;
        end
      end

      // purge the cache block at cur, then re-anchor base from before
      S_PG0: begin
        before_nxt = rh.prv;
        ret_nxt    = S_PG1;
        st_nxt     = S_FB0;
      end

      S_PG1: begin
        rd_idx = before_r;
        st_nxt = S_PG2;
      end

      S_PG2: begin
        base_nxt = rh.nxt;
        rd_idx   = rh.nxt;
        st_nxt   = S_PG3;
      end

      S_PG3: begin
        cur_nxt = rh.nxt;
        st_nxt  = S_CD;
      end

      S_CD: begin
        rd_idx = base_r;
        st_nxt = S_CD1;
      end

      S_CD1: begin
        if (rh.used || rh.size < need_r) begin
          st_nxt = S_LP;
        end else begin
          hB_nxt = rh;
          st_nxt = S_SP0;
        end
      end

      S_SP0: begin
        if ({left_w, 4'b0000} > (IW + 4)'(mf_r)) begin
          hdr_we      = 1'b1;
          hdr_wi      = nb_w;
          wr_hdr.head = 1'b1;
          wr_hdr.size = left_w;
          wr_hdr.nxt  = hB_r.nxt;
          wr_hdr.prv  = base_r;
          st_nxt      = S_SP1;
        end else begin
          st_nxt = S_SP3;
        end
      end

      S_SP1: begin
        rd_idx = hB_r.nxt;
        st_nxt = S_SP2;
      end

      S_SP2: begin
        hdr_we      = 1'b1;
        hdr_wi      = hB_r.nxt;
        wr_hdr      = rh;
        wr_hdr.prv  = nb_w;
        hB_nxt.size = need_r;
        hB_nxt.nxt  = nb_w;
        st_nxt      = S_SP3;
      end

      S_SP3: begin
        hdr_we       = 1'b1;
        hdr_wi       = base_r;
        wr_hdr       = hB_r;
        wr_hdr.tag   = tag_r;
        wr_hdr.used  = 1'b1;
        wr_hdr.owner = owner_r;
        rover_nxt    = hB_r.nxt;
        res_nxt      = AW'(base_r + IW'(1));
        if (owner_r != '0 && 32'(owner_r) < pza_pkg::HANDLE_COUNT) begin
          hnd_we = 1'b1;
          hnd_wa = HW'(owner_r);
          hnd_wd = AW'(base_r + IW'(1));
        end
        st_nxt = S_DONE;
      end

      // free_level_tags: walk the list from the sentinel
      S_FL0: begin
        if (b_r == pza_pkg::SENT_IDX || guard_r == '0) begin
          st_nxt = S_DONE;
        end else begin
          guard_nxt = guard_r - GW'(1);
          rd_idx    = b_r;
          st_nxt    = S_FL1;
        end
      end

      S_FL1: begin
        if (rh.used && (rh.tag inside {pza_pkg::TAG_LEVEL, pza_pkg::TAG_LEVSPEC})) begin
          hA_nxt  = rh;
          ret_nxt = S_FL2;
          st_nxt  = S_FB0;
        end else begin
          b_nxt  = rh.nxt;
          st_nxt = S_FL0;
        end
      end

      S_FL2: begin
        rd_idx = b_r;
        st_nxt = S_FL3;
      end

      S_FL3: begin
        b_nxt  = rh.nxt;
        st_nxt = S_FL0;
      end

      default: st_nxt = S_IDLE;
    endcase

    if (hdr_we && hdr_wi == pza_pkg::SENT_IDX) begin
      sent_next_nxt = wr_hdr.nxt;
      sent_prev_nxt = wr_hdr.prv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_CLR;
      ret_r        <= S_IDLE;
      clr_cnt_r    <= '0;
      clr_hnd_r    <= 1'b1;
      clr_op_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      rover_r      <= '0;
      sent_next_r  <= '0;
      sent_prev_r  <= '0;
      hp_r         <= pza_pkg::HP_RESET;
      mf_r         <= pza_pkg::MF_RESET;
      rd_sent_r    <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      ret_r        <= ret_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_hnd_r    <= clr_hnd_nxt;
      clr_op_r     <= clr_op_nxt;
      out_valid_r  <= out_valid_nxt;
      rover_r      <= rover_nxt;
      sent_next_r  <= sent_next_nxt;
      sent_prev_r  <= sent_prev_nxt;
      rd_sent_r    <= (rd_idx == pza_pkg::SENT_IDX);
      if (cfg_wr_en) begin
        if (cfg_addr == pza_pkg::CFG_HEAP) begin
          hp_r <= cfg_wdata;
        end else begin
          mf_r <= cfg_wdata[10:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    tag_r        <= tag_nxt;
    owner_r      <= owner_nxt;
    need_r       <= need_nxt;
    b_r          <= b_nxt;
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    base_r       <= base_nxt;
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    before_r     <= before_nxt;
    guard_r      <= guard_nxt;
    hA_r         <= hA_nxt;
    hB_r         <= hB_nxt;
    status_r     <= status_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while busy");

  a_rover_range: assert property (@(posedge clk) disable iff (!rst_n)
    rover_r <= pza_pkg::SENT_IDX)
    else $error("rover points past the sentinel");

  a_sent_range: assert property (@(posedge clk) disable iff (!rst_n)
    sent_next_r <= pza_pkg::SENT_IDX && sent_prev_r <= pza_pkg::SENT_IDX)
    else $error("sentinel link out of range");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> (!hdr_we && !hnd_we))
    else $error("memory written while idle");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_addr_r)))
    else $error("pending result overwritten");

endmodule
